// ===== src/timestamp_to_pcr_converter_core_assert.svh =====
// Assertion macros used by the converter's top-level RTL file.
`ifndef TIMESTAMP_TO_PCR_CONVERTER_CORE_ASSERT_SVH
`define TIMESTAMP_TO_PCR_CONVERTER_CORE_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define TPC_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define TPC_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");
`endif

// ===== src/tpc_pkg.sv =====
// Package with constants and types of the time stamp converter.
`default_nettype none
package tpc_pkg;
   localparam int StampWidth = 64;
   localparam int PcrWidth   = 42;
   localparam int OriginWidth = 4;
   localparam logic [63:0] ClockHz = 64'd27000000;
   localparam logic [63:0] PcrWrap = 64'd2576980377600;
   localparam logic [0:0] RegTickRate = 1'd0;
   localparam logic [0:0] RegStampOrigin = 1'd1;

   // Cycles through tpc_mul27: partial products, then their sum.
   localparam int MulLat = 2;
   // The wrap is 75 * 2^35: the low bits pass, the rest is reduced modulo 75.
   localparam int WrapLow = 35;
   localparam int WrapShift = 36;
   localparam logic [6:0] WrapMult = 7'd75;
   // floor(2^36 / 75), the reciprocal used for the modulo-75 step.
   localparam logic [29:0] WrapRecip = 30'd916259689;

   // Per-word control that travels with the conversion pipeline.
   typedef struct packed {
      logic                   valid;
      logic                   stamp_valid;
      logic                   coarse;
      logic                   passthru;
      logic [OriginWidth-1:0] origin;
   } ctl_type;
endpackage
`default_nettype wire

// ===== src/tpc_if.sv =====
// Channel interfaces of the time stamp converter.
`default_nettype none
interface tpc_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] raw_stamp;
   modport source (output valid, output raw_stamp, input ready);
   modport sink (input valid, input raw_stamp, output ready);
endinterface

interface tpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [41:0] pcr_value;
   logic        stamp_valid;
   logic        coarse_path;
   logic [3:0]  origin_code;
   modport source (output valid, output pcr_value, output stamp_valid,
                   output coarse_path, output origin_code, input ready);
   modport sink (input valid, input pcr_value, input stamp_valid,
                 input coarse_path, input origin_code, output ready);
endinterface

interface tpc_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [63:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== src/tpc_mul27.sv =====
// Pipelined multiply of a 64-bit value by 27e6, truncated to 64 bits.
`default_nettype none
module tpc_mul27 (
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire logic [63:0] value,
   output logic [63:0]      product
);
   import tpc_pkg::*;
   // 27e6 fits in 25 bits; the value is split in two 32-bit halves.
   // Only the low 32 bits of the upper partial product reach the result.
   logic [56:0] lo_ff, lo_in;
   logic [31:0] hi_ff, hi_in;
   logic [63:0] prod_ff, prod_in;

   assign lo_in = 57'(value[31:0]) * 57'(ClockHz[24:0]);
   assign hi_in = 32'(57'(value[63:32]) * 57'(ClockHz[24:0]));
   assign prod_in = 64'(lo_ff) + {hi_ff, 32'd0};
   assign product = prod_ff;

   always_ff @(posedge clock) begin
      if (enable) begin
         lo_ff <= lo_in;
         hi_ff <= hi_in;
         prod_ff <= prod_in;
      end
   end
endmodule
`default_nettype wire

// ===== src/tpc_divider.sv =====
// Fully pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module tpc_divider #(
   parameter int Width = 64
) (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire logic [Width-1:0] dividend,
   input  wire logic [Width-1:0] divisor,
   output logic [Width-1:0]      quotient
);
   logic [Width-1:0] rem_ff [1:Width-1];
   logic [Width-1:0] quo_ff [1:Width];
   logic [Width-1:0] div_ff [1:Width-1];

   for (genvar s = 0; s < Width; s++) begin : g_stage
      logic [Width-1:0] rem_cur;
      logic [Width-1:0] quo_cur;
      logic [Width-1:0] div_cur;
      logic [Width:0]   trial;
      logic [Width:0]   diff;
      if (s == 0) begin : g_first
         assign rem_cur = '0;
         assign quo_cur = dividend;
         assign div_cur = divisor;
      end else begin : g_next
         assign rem_cur = rem_ff[s];
         assign quo_cur = quo_ff[s];
         assign div_cur = div_ff[s];
      end
      always_comb begin
         trial = {rem_cur, quo_cur[Width-1]};
         diff = trial - {1'b0, div_cur};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            quo_ff[s+1] <= {quo_cur[Width-2:0], ~diff[Width]};
         end
      end
      // The last stage only delivers the quotient.
      if (s < Width-1) begin : g_pass
         always_ff @(posedge clock) begin
            if (enable) begin
               if (!diff[Width]) begin
                  rem_ff[s+1] <= diff[Width-1:0];
               end else begin
                  rem_ff[s+1] <= trial[Width-1:0];
               end
               div_ff[s+1] <= div_cur;
            end
         end
      end
   end

   assign quotient = quo_ff[Width];
endmodule
`default_nettype wire

// ===== src/timestamp_to_pcr_converter_core.sv =====
// Top level of the time stamp to 27 MHz clock converter.
// Usage: stamp words enter on the req channel (valid/ready) and leave on
// the rsp channel, one response word per request word, in order.
// Registers are to be written on the csr channel while the block is idle;
// the block does not check it. Index 0: tick rate, index 1: origin code.
// The conversion is one long lockstep pipeline: a 2-stage multiply by
// 27e6, a 64-stage divide by the rate, a 2-stage multiply of the quotient
// for the coarse path, and a 2-stage reduction modulo the wrap, followed
// by an output register. The wrap is 75 * 2^35, so the low 35 bits pass
// through and the upper bits are reduced modulo 75 by a reciprocal
// multiply and one correcting subtract in the output register.
// Throughput is one word per cycle while the receiver does not stall.
// When the receiver stalls, the whole pipeline freezes and nothing is
// lost; the request side stays ready while the output register is empty
// or being drained. Reset clears the valid bits and restores the tick
// rate to 27,000,000 and the origin code to zero; no clearing pass.
`default_nettype none
module timestamp_to_pcr_converter_core (
   input  wire logic   clock,
   input  wire logic   reset,
   tpc_req_if.sink     req,
   tpc_rsp_if.source   rsp,
   tpc_csr_if.sink     csr
);
   import tpc_pkg::*;
   `include "timestamp_to_pcr_converter_core_assert.svh"

   localparam int DivLat = StampWidth;
   localparam int ModLat = 2;
   // Stages: mul (MulLat), divide (DivLat), mul (MulLat), modulo (ModLat).
   localparam int Lat1 = MulLat;
   localparam int Lat2 = Lat1 + DivLat;
   localparam int Lat3 = Lat2 + MulLat;
   localparam int Lat4 = Lat3 + ModLat;

   logic [63:0] rate_ff;
   logic [OriginWidth-1:0] origin_ff;
   logic        adv;
   logic        out_valid_ff;

   // The pipeline moves whenever the output register can take a word.
   assign adv = !out_valid_ff || rsp.ready;
   assign req.ready = adv;
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= ClockHz;
         origin_ff <= '0;
      end else if (csr.valid) begin
         if (csr.index == RegTickRate) begin
            rate_ff <= csr.data;
         end else begin
            origin_ff <= csr.data[OriginWidth-1:0];
         end
      end
   end

   // Control and raw stamp shift alongside the arithmetic.
   ctl_type     ctl_ff [Lat4+1];
   ctl_type     ctl_in [Lat4+1];
   logic [63:0] stamp_ff [Lat3+1];
   ctl_type     ctl0;
   logic [63:0] prod1;
   logic        coarse_now;

   // The wrap test only compares the truncated product with the stamp.
   assign coarse_now = prod1 < stamp_ff[Lat1];

   always_comb begin
      ctl0.valid = req.valid;
      ctl0.stamp_valid = rate_ff != '0;
      ctl0.passthru = rate_ff == ClockHz;
      ctl0.coarse = 1'b0;
      ctl0.origin = origin_ff;
   end

   always_comb begin
      for (int i = 0; i <= Lat4; i++) begin
         ctl_in[i] = ctl_ff[i];
      end
      if (adv) begin
         ctl_in[0] = ctl0;
         for (int i = 1; i <= Lat4; i++) begin
            ctl_in[i] = ctl_ff[i-1];
         end
         // Wrap decision becomes known after the first multiplier.
         ctl_in[Lat1+1].coarse = ctl_ff[Lat1].stamp_valid &&
                                 !ctl_ff[Lat1].passthru && coarse_now;
      end
      if (reset) begin
         for (int i = 0; i <= Lat4; i++) begin
            ctl_in[i].valid = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i <= Lat4; i++) begin
         ctl_ff[i] <= ctl_in[i];
      end
      if (adv) begin
         stamp_ff[0] <= req.raw_stamp;
         for (int i = 1; i <= Lat3; i++) begin
            stamp_ff[i] <= stamp_ff[i-1];
         end
      end
   end

   // Stage 1: stamp * 27e6.
   tpc_mul27 u_mul1 (.clock(clock), .enable(adv), .value(stamp_ff[0]),
                     .product(prod1));
   // Rate travels with each word.
   logic [63:0] rate_pipe_ff [Lat1+1];
   always_ff @(posedge clock) begin
      if (adv) begin
         rate_pipe_ff[0] <= rate_ff;
         for (int i = 1; i <= Lat1; i++) begin
            rate_pipe_ff[i] <= rate_pipe_ff[i-1];
         end
      end
   end

   // Stage 2: divide, the dividend picked by the wrap test.
   logic [63:0] dividend;
   logic [63:0] quo1;
   logic [63:0] divisor1;
   assign dividend = coarse_now ? stamp_ff[Lat1] : prod1;
   // A zero rate only feeds a result that is forced to zero later.
   assign divisor1 = rate_pipe_ff[Lat1];
   tpc_divider #(.Width(StampWidth)) u_div (
      .clock(clock), .enable(adv), .dividend(dividend), .divisor(divisor1),
      .quotient(quo1));

   // Stage 3: quotient * 27e6 for the coarse path.
   logic [63:0] prod2;
   tpc_mul27 u_mul2 (.clock(clock), .enable(adv), .value(quo1),
                     .product(prod2));
   logic [63:0] quo_d_ff [MulLat];
   always_ff @(posedge clock) begin
      if (adv) begin
         quo_d_ff[0] <= quo1;
         for (int i = 1; i < MulLat; i++) begin
            quo_d_ff[i] <= quo_d_ff[i-1];
         end
      end
   end

   // Stage 4: reduce modulo the wrap. The upper 29 bits are divided by 75
   // through the reciprocal; the estimate is low by at most one, so the
   // remainder stays below 150 and needs one more subtract at the output.
   ctl_type     c3;
   logic [63:0] val3;
   logic [58:0] mprod_ff;
   logic [28:0] mhi_ff;
   logic [WrapLow-1:0] mlo_ff;
   logic [WrapLow-1:0] mlo2_ff;
   logic [28:0] mq75;
   logic [28:0] mdiff;
   logic [7:0]  mrem_ff;
   assign c3 = ctl_ff[Lat3];
   always_comb begin
      if (c3.passthru) begin
         val3 = stamp_ff[Lat3];
      end else if (c3.coarse) begin
         val3 = prod2;
      end else begin
         val3 = quo_d_ff[MulLat-1];
      end
   end
   assign mq75 = 29'(mprod_ff[58:WrapShift]) * 29'(WrapMult);
   assign mdiff = mhi_ff - mq75;
   always_ff @(posedge clock) begin
      if (adv) begin
         mprod_ff <= 59'(val3[63:WrapLow]) * 59'(WrapRecip);
         mhi_ff <= val3[63:WrapLow];
         mlo_ff <= val3[WrapLow-1:0];
         mrem_ff <= mdiff[7:0];
         mlo2_ff <= mlo_ff;
      end
   end

   // Output register.
   ctl_type     c4;
   logic [6:0]  mod_hi;
   logic [PcrWidth-1:0] pcr_ff;
   logic        sv_ff, coarse_ff;
   logic [OriginWidth-1:0] org_ff;
   assign c4 = ctl_ff[Lat4];
   assign mod_hi = (mrem_ff >= 8'(WrapMult)) ? 7'(mrem_ff - 8'(WrapMult)) :
                                                mrem_ff[6:0];
   always_ff @(posedge clock) begin
      if (adv) begin
         pcr_ff <= c4.stamp_valid ? {mod_hi, mlo2_ff} : '0;
         sv_ff <= c4.stamp_valid;
         coarse_ff <= c4.coarse;
         org_ff <= c4.origin;
      end
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= c4.valid;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.pcr_value = pcr_ff;
   assign rsp.stamp_valid = sv_ff;
   assign rsp.coarse_path = coarse_ff;
   assign rsp.origin_code = org_ff;

   `TPC_ASSERT_NEXT(a_stall_holds, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(rsp.pcr_value))
   `TPC_ASSERT_IMPL(a_invalid_zero, clock, reset, rsp.valid && !rsp.stamp_valid,
      rsp.pcr_value == '0 && !rsp.coarse_path)
   `TPC_ASSERT_IMPL(a_ready_adv, clock, reset, !rsp.valid, req.ready)
endmodule
`default_nettype wire
